[rtl/sdcs_pkg.sv]
// Shared types and constants of the sprite DMA clock scheduler.
package sdcs_pkg;

  // Ticks per processor slot
  localparam int unsigned CpuDivide = 3;
  // Tick counter runs modulo two slots so that slot parity is known
  localparam int unsigned PhaseMod  = 2 * CpuDivide;
  localparam int unsigned PhaseW    = $clog2(PhaseMod);

  // Reset value of the sample phase step
  localparam logic [31:0] StepReset = 32'd35275899;

  // Stream widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    OpTick     = 2'd0,
    OpDmaStart = 2'd1,
    OpReset    = 2'd2,
    OpNone     = 2'd3
  } op_e;

  // One result item
  typedef struct packed {
    logic        cpu_reset;
    logic        cpu_nmi;
    logic        sample_ready;
    logic [7:0]  oam_data;
    logic [7:0]  oam_index;
    logic        oam_write;
    logic [15:0] read_address;
    logic        read_request;
    logic        cpu_step;
  } res_t;

endpackage

[rtl/sdcs_core.sv]
// Scheduler state and per-request slot, DMA and audio timer logic.
module sdcs_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  sdcs_pkg::op_e           op_i,
  input  logic [7:0]              page_i,
  input  logic [7:0]              rdata_i,
  input  logic                    nmi_i,
  input  logic [31:0]             step_i,
  output sdcs_pkg::res_t          res_o
);

  localparam logic [sdcs_pkg::PhaseW-1:0] PhaseLast =
    sdcs_pkg::PhaseW'(sdcs_pkg::PhaseMod - 1);
  localparam logic [sdcs_pkg::PhaseW-1:0] PhaseHalf =
    sdcs_pkg::PhaseW'(sdcs_pkg::CpuDivide);

  logic [sdcs_pkg::PhaseW-1:0] phase_q, phase_d;
  logic        active_q, active_d;
  logic        waiting_q, waiting_d;
  logic [7:0]  page_q, page_d;
  logic [7:0]  index_q, index_d;
  logic [7:0]  byte_q, byte_d;
  logic        pending_q, pending_d;
  logic [31:0] audio_q, audio_d;

  logic        slot;
  logic        odd;
  logic [7:0]  byte_v;
  logic [7:0]  index_inc;
  logic [32:0] audio_sum;

  // Slot falls on tick phases 0 and CpuDivide
  assign slot      = (phase_q == '0) || (phase_q == PhaseHalf);
  assign odd       = phase_q[0];
  assign byte_v    = pending_q ? rdata_i : byte_q;
  assign index_inc = index_q + 8'd1;
  assign audio_sum = {1'b0, audio_q} + {1'b0, step_i};

  // Next state and result for one request
  always_comb begin
    phase_d   = phase_q;
    active_d  = active_q;
    waiting_d = waiting_q;
    page_d    = page_q;
    index_d   = index_q;
    byte_d    = byte_q;
    pending_d = pending_q;
    audio_d   = audio_q;
    res_o     = '0;
    case (op_i)
      sdcs_pkg::OpDmaStart: begin
        page_d   = page_i;
        index_d  = 8'd0;
        active_d = 1'b1;
      end
      sdcs_pkg::OpReset: begin
        phase_d         = '0;
        res_o.cpu_reset = 1'b1;
      end
      sdcs_pkg::OpTick: begin
        // Latch the byte answering last tick's read
        byte_d    = byte_v;
        pending_d = 1'b0;
        if (slot) begin
          if (active_q) begin
            if (waiting_q) begin
              if (odd) begin
                waiting_d = 1'b0;
              end
            end else if (!odd) begin
              res_o.read_request = 1'b1;
              res_o.read_address = {page_q, index_q};
              pending_d          = 1'b1;
            end else begin
              res_o.oam_write = 1'b1;
              res_o.oam_index = index_q;
              res_o.oam_data  = byte_v;
              index_d         = index_inc;
              if (index_inc == 8'd0) begin
                active_d  = 1'b0;
                waiting_d = 1'b1;
              end
            end
          end else begin
            res_o.cpu_step = 1'b1;
          end
        end
        // Advance the audio phase, flag the carry
        audio_d            = audio_sum[31:0];
        res_o.sample_ready = audio_sum[32];
        res_o.cpu_nmi      = nmi_i;
        phase_d            = (phase_q == PhaseLast) ? '0 : phase_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State registers, updated on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      active_q  <= 1'b0;
      waiting_q <= 1'b1;
      page_q    <= 8'd0;
      index_q   <= 8'd0;
      byte_q    <= 8'd0;
      pending_q <= 1'b0;
      audio_q   <= 32'd0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      active_q  <= active_d;
      waiting_q <= waiting_d;
      page_q    <= page_d;
      index_q   <= index_d;
      byte_q    <= byte_d;
      pending_q <= pending_d;
      audio_q   <= audio_d;
    end
  end

endmodule

[rtl/sprite_dma_clock_scheduler_top.sv]
// Top level of the sprite DMA clock scheduler: stream ports and result register.
//
// Channel  Direction  Handshake                   Payload
// s_axis   in         s_axis_tvalid/tready        tuser opcode, tdata page/data/nmi
// m_axis   out        m_axis_tvalid/tready        tdata one result
// cfg      in         cfg_valid_i/cfg_ready_o     cfg_data_i sample phase step
//
// One request per clock while the output is not stalled; its result appears in the output register on the next cycle.
// The result is held in the single result register after the scheduler logic.
// A request is taken whenever the output register is empty or being emptied.
// Reset clears the scheduler state and loads the default sample phase step.
module sprite_dma_clock_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] dma_page_in, [15:8] read_data, [16] ppu_nmi, [23:17] zero
  input  logic [sdcs_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [sdcs_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] cpu_step, [1] read_request, [17:2] read_address, [18] oam_write,
  // [26:19] oam_index, [34:27] oam_data, [35] sample_ready, [36] cpu_nmi,
  // [37] cpu_reset, [39:38] zero
  output logic [sdcs_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i
);

  logic                  accept;
  logic                  out_valid_q;
  sdcs_pkg::res_t        res;
  sdcs_pkg::res_t        res_q;
  logic [31:0]           step_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  sdcs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .op_i    (sdcs_pkg::op_e'(s_axis_tuser)),
    .page_i  (s_axis_tdata[7:0]),
    .rdata_i (s_axis_tdata[15:8]),
    .nmi_i   (s_axis_tdata[16]),
    .step_i  (step_q),
    .res_o   (res)
  );

  // Hold the sample phase step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sdcs_pkg::StepReset;
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

  // Output valid: set on a request, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(sdcs_pkg::OutDataW - $bits(sdcs_pkg::res_t)){1'b0}}, res_q};

endmodule
